// ----- hdl/mme_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the matrix multiply engine.
package mme_pkg;

    localparam int VALUE_W   = 16;
    localparam int PROD_W    = 2 * VALUE_W;
    localparam int SUM_W     = 35;
    localparam int IDX_W     = 3;
    localparam int DIM_W     = 4;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 4;

    localparam int MAX_DIM_DEFAULT = 8;

    localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic rd_en;
        logic acc_clear;
        logic emit;
        logic last;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// ----- hdl/mme_ctrl.sv -----
// Controller: configuration registers, input handshake and the row/column/inner-index sequencer.
module mme_ctrl #(
    parameter int MAX_DIM = mme_pkg::MAX_DIM_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mme_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mme_pkg::CMD_W-1:0]     s_cmd,
    input  logic [mme_pkg::IDX_W-1:0]     s_row,
    input  logic [mme_pkg::IDX_W-1:0]     s_col,
    output mme_pkg::dp_cmd_t              dp_cmd,
    input  mme_pkg::dp_status_t           dp_status,
    output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] wr_addr,
    output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] rd_addr_a,
    output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] rd_addr_b,
    output logic [mme_pkg::IDX_W-1:0]     out_row,
    output logic [mme_pkg::IDX_W-1:0]     out_col
);
    import mme_pkg::*;

    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int AW     = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int CALC_W = 7;

    state_t state_reg, state_next;
    logic [DIM_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;
    logic [CNT_W-1:0] r_reg, r_next, c_reg, c_next, k_reg, k_next;
    logic             drain_reg, drain_next;

    logic [DIM_W-1:0] nr, nk, nc;
    logic             accept, load_a_ok, load_b_ok, k_last, r_last, c_last;

    // Dimensions above the store size act as the store size
    assign nr = (rows_a_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rows_a_reg;
    assign nk = (inner_dim_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : inner_dim_reg;
    assign nc = (cols_b_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cols_b_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign load_a_ok = (DIM_W'(s_row) < nr) && (DIM_W'(s_col) < nk);
    assign load_b_ok = (DIM_W'(s_row) < nk) && (DIM_W'(s_col) < nc);

    assign k_last = (DIM_W'(k_reg) + DIM_W'(1)) == nk;
    assign r_last = (DIM_W'(r_reg) + DIM_W'(1)) == nr;
    assign c_last = (DIM_W'(c_reg) + DIM_W'(1)) == nc;

    assign wr_addr   = AW'(CALC_W'(s_row) * CALC_W'(MAX_DIM) + CALC_W'(s_col));
    assign rd_addr_a = AW'(CALC_W'(r_reg) * CALC_W'(MAX_DIM) + CALC_W'(k_reg));
    assign rd_addr_b = AW'(CALC_W'(k_reg) * CALC_W'(MAX_DIM) + CALC_W'(c_reg));
    assign out_row   = IDX_W'(r_reg);
    assign out_col   = IDX_W'(c_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg    <= DIM_RESET;
            inner_dim_reg <= DIM_RESET;
            cols_b_reg    <= DIM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ROWS_A:    rows_a_reg    <= cfg_data;
                CFG_INNER_DIM: inner_dim_reg <= cfg_data;
                CFG_COLS_B:    cols_b_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            r_reg     <= '0;
            c_reg     <= '0;
            k_reg     <= '0;
            drain_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            k_reg     <= k_next;
            drain_reg <= drain_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        k_next     = k_reg;
        drain_next = drain_reg;
        dp_cmd     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                dp_cmd.acc_clear = 1'b1;
                if (accept) begin
                    unique case (s_cmd)
                        CMD_LOAD_A: dp_cmd.wr_a = load_a_ok;
                        CMD_LOAD_B: dp_cmd.wr_b = load_b_ok;
                        CMD_COMPUTE: begin
                            // Empty product: drop the transaction without results
                            if (nr != '0 && nc != '0) begin
                                r_next     = '0;
                                c_next     = '0;
                                k_next     = '0;
                                state_next = (nk == '0) ? ST_EMIT : ST_MAC;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MAC: begin
                dp_cmd.rd_en = 1'b1;
                if (k_last) begin
                    k_next     = '0;
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + CNT_W'(1);
                end
            end
            ST_DRAIN: begin
                // Wait for read and multiply stages to land in the accumulator
                drain_next = 1'b1;
                if (drain_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (dp_status.out_free) begin
                    dp_cmd.emit      = 1'b1;
                    dp_cmd.acc_clear = 1'b1;
                    dp_cmd.last      = r_last && c_last;
                    if (r_last && c_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        if (c_last) begin
                            c_next = '0;
                            r_next = r_reg + CNT_W'(1);
                        end else begin
                            c_next = c_reg + CNT_W'(1);
                        end
                        state_next = (nk == '0) ? ST_EMIT : ST_MAC;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- hdl/mme_dp.sv -----
// Datapath: A and B stores, multiply-accumulate pipeline and the result output register.
module mme_dp #(
    parameter int MAX_DIM = mme_pkg::MAX_DIM_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  mme_pkg::dp_cmd_t                 dp_cmd,
    output mme_pkg::dp_status_t              dp_status,
    input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] wr_addr,
    input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] rd_addr_a,
    input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] rd_addr_b,
    input  logic signed [mme_pkg::VALUE_W-1:0] wr_data,
    input  logic [mme_pkg::IDX_W-1:0]        out_row,
    input  logic [mme_pkg::IDX_W-1:0]        out_col,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [mme_pkg::IDX_W-1:0]        m_out_row,
    output logic [mme_pkg::IDX_W-1:0]        m_out_col,
    output logic signed [mme_pkg::SUM_W-1:0] m_product_value,
    output logic                             m_last
);
    import mme_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic signed [VALUE_W-1:0] store_a_reg [DEPTH];
    logic signed [VALUE_W-1:0] store_b_reg [DEPTH];

    logic signed [VALUE_W-1:0] a_rd_reg, b_rd_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [SUM_W-1:0]   acc_reg;
    logic                      rd_vld_reg, prod_vld_reg;

    logic                      out_valid_reg, out_last_reg;
    logic [IDX_W-1:0]          out_row_reg, out_col_reg;
    logic signed [SUM_W-1:0]   out_value_reg;

    assign dp_status.out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (dp_cmd.wr_a) begin
            store_a_reg[wr_addr] <= wr_data;
        end
        if (dp_cmd.rd_en) begin
            a_rd_reg <= store_a_reg[rd_addr_a];
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.wr_b) begin
            store_b_reg[wr_addr] <= wr_data;
        end
        if (dp_cmd.rd_en) begin
            b_rd_reg <= store_b_reg[rd_addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= dp_cmd.rd_en;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= a_rd_reg * b_rd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (dp_cmd.acc_clear) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + SUM_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (dp_cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Capture the finished sum before the accumulator clears on the same edge
    always_ff @(posedge aclk) begin
        if (dp_cmd.emit) begin
            out_row_reg   <= out_row;
            out_col_reg   <= out_col;
            out_value_reg <= acc_reg;
            out_last_reg  <= dp_cmd.last;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_out_row       = out_row_reg;
    assign m_out_col       = out_col_reg;
    assign m_product_value = out_value_reg;
    assign m_last          = out_last_reg;

endmodule

// ----- hdl/matrix_multiply_engine_unit.sv -----
// Top level of the matrix multiply engine: controller and datapath.
//
// Computes C = A * B on signed Q8.8 elements with exact signed Q19.16 sums (35 bits).
// A load transaction (cmd 0 for A, 1 for B) writes one element and is ignored when its row
// or column lies outside the configured shape; loads are taken back to back.
// A compute transaction (cmd 2) emits rows_a * cols_b results in row-major order, the final
// one flagged by m_last. Each result is built from one store read per inner index through the
// single multiply-accumulate unit, a drain of the registered read and multiply stages, and a
// load of the output register; with inner_dim of zero only the output register is loaded.
// Output backpressure holds the sequencer in place. The next transaction is taken once the
// last result sits in the output register. Store entries are undefined until loaded. The
// user must write the dimension registers only while the engine is idle, which the block
// itself does not enforce; values above MAX_DIM act as MAX_DIM.
module matrix_multiply_engine_unit #(
    parameter int MAX_DIM = mme_pkg::MAX_DIM_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [mme_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mme_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [mme_pkg::CMD_W-1:0]        s_cmd,
    input  logic [mme_pkg::IDX_W-1:0]        s_row,
    input  logic [mme_pkg::IDX_W-1:0]        s_col,
    input  logic signed [mme_pkg::VALUE_W-1:0] s_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [mme_pkg::IDX_W-1:0]        m_out_row,
    output logic [mme_pkg::IDX_W-1:0]        m_out_col,
    output logic signed [mme_pkg::SUM_W-1:0] m_product_value,
    output logic                             m_last
);
    import mme_pkg::*;

    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

    dp_cmd_t          dp_cmd;
    dp_status_t       dp_status;
    logic [AW-1:0]    wr_addr, rd_addr_a, rd_addr_b;
    logic [IDX_W-1:0] out_row, out_col;

    mme_ctrl #(
        .MAX_DIM(MAX_DIM)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .s_row     (s_row),
        .s_col     (s_col),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .wr_addr   (wr_addr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .out_row   (out_row),
        .out_col   (out_col)
    );

    mme_dp #(
        .MAX_DIM(MAX_DIM)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .dp_cmd          (dp_cmd),
        .dp_status       (dp_status),
        .wr_addr         (wr_addr),
        .rd_addr_a       (rd_addr_a),
        .rd_addr_b       (rd_addr_b),
        .wr_data         (s_value),
        .out_row         (out_row),
        .out_col         (out_col),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_row       (m_out_row),
        .m_out_col       (m_out_col),
        .m_product_value (m_product_value),
        .m_last          (m_last)
    );

endmodule

// ----- bench/matrix_multiply_engine_unit_tb.sv -----
// Self-checking testbench for the matrix multiply engine: loads, shape changes and product checks.
module matrix_multiply_engine_unit_tb;
    import mme_pkg::*;

    localparam int DIM          = MAX_DIM_DEFAULT;
    localparam int SETTLE       = DIM + 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;

    localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

    localparam logic signed [VALUE_W-1:0] VAL_MOST_NEG = 16'sh8000;
    localparam logic signed [VALUE_W-1:0] VAL_MOST_POS = 16'sh7FFF;
    localparam logic signed [VALUE_W-1:0] VAL_MINUS_ONE = 16'shFFFF;

    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } c_elem_t;

    // Holds the A and B stores and the shape, and the product elements still due.
    class product_tracker;
        logic signed [VALUE_W-1:0] a_mem [DIM*DIM];
        logic signed [VALUE_W-1:0] b_mem [DIM*DIM];
        bit  a_loaded [DIM*DIM];
        bit  b_loaded [DIM*DIM];
        int  n_rows  = DIM;
        int  n_inner = DIM;
        int  n_cols  = DIM;
        int  mismatches = 0;
        c_elem_t due_q[$];

        function void set_dims(logic [DIM_W-1:0] r, logic [DIM_W-1:0] k, logic [DIM_W-1:0] c);
            n_rows  = (int'(r) > DIM) ? DIM : int'(r);
            n_inner = (int'(k) > DIM) ? DIM : int'(k);
            n_cols  = (int'(c) > DIM) ? DIM : int'(c);
        endfunction

        function void apply_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] row,
                                 logic [IDX_W-1:0] col, logic signed [VALUE_W-1:0] val);
            logic signed [SUM_W-1:0]  acc;
            logic signed [PROD_W-1:0] term;
            c_elem_t                  elem;
            case (cmd)
                CMD_LOAD_A: begin
                    if (int'(row) < n_rows && int'(col) < n_inner) begin
                        a_mem[int'(row)*DIM + int'(col)]    = val;
                        a_loaded[int'(row)*DIM + int'(col)] = 1'b1;
                    end
                end
                CMD_LOAD_B: begin
                    if (int'(row) < n_inner && int'(col) < n_cols) begin
                        b_mem[int'(row)*DIM + int'(col)]    = val;
                        b_loaded[int'(row)*DIM + int'(col)] = 1'b1;
                    end
                end
                CMD_COMPUTE: begin
                    for (int r = 0; r < n_rows; r++) begin
                        for (int c = 0; c < n_cols; c++) begin
                            acc = '0;
                            for (int k = 0; k < n_inner; k++) begin
                                term = a_mem[r*DIM + k] * b_mem[k*DIM + c];
                                acc  = acc + SUM_W'(term);
                            end
                            elem.row  = IDX_W'(r);
                            elem.col  = IDX_W'(c);
                            elem.sum  = acc;
                            elem.last = (r == n_rows - 1) && (c == n_cols - 1);
                            due_q.push_back(elem);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        function void check_element(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                    logic signed [SUM_W-1:0] sum, logic last);
            c_elem_t want;
            if (due_q.size() == 0) begin
                report($sformatf("unexpected element (%0d,%0d) sum %0d last %b",
                                 row, col, sum, last));
                return;
            end
            want = due_q.pop_front();
            if (want.row !== row || want.col !== col || want.sum !== sum || want.last !== last)
                report($sformatf("expected (%0d,%0d) sum %0d last %b, got (%0d,%0d) sum %0d last %b",
                                 want.row, want.col, want.sum, want.last, row, col, sum, last));
        endfunction
    endclass

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_wr_en;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]            cfg_data;
    logic                        s_valid;
    logic                        s_ready;
    logic [CMD_W-1:0]            s_cmd;
    logic [IDX_W-1:0]            s_row;
    logic [IDX_W-1:0]            s_col;
    logic signed [VALUE_W-1:0]   s_value;
    logic                        m_valid;
    logic                        m_ready;
    logic [IDX_W-1:0]            m_out_row;
    logic [IDX_W-1:0]            m_out_col;
    logic signed [SUM_W-1:0]     m_product_value;
    logic                        m_last;

    bit no_gaps   = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;

    product_tracker tracker = new();

    matrix_multiply_engine_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_row           (s_row),
        .s_col           (s_col),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_row       (m_out_row),
        .m_out_col       (m_out_col),
        .m_product_value (m_product_value),
        .m_last          (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MOST_NEG;
            1:       return VAL_MOST_POS;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // Mostly inside the shape, sometimes anywhere so that out-of-range loads occur.
    function automatic logic [IDX_W-1:0] draw_index(int n);
        if (n == 0 || $urandom_range(0, 4) == 0)
            return IDX_W'($urandom_range(0, DIM - 1));
        return IDX_W'($urandom_range(0, n - 1));
    endfunction

    task automatic send_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] row,
                             logic [IDX_W-1:0] col, logic signed [VALUE_W-1:0] val);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_row   <= row;
        s_col   <= col;
        s_value <= val;
        do @(posedge aclk); while (!s_ready);
        tracker.apply_item(cmd, row, col, val);
    endtask

    // Wait for the engine to drain, then write every dimension register.
    task automatic set_shape(logic [DIM_W-1:0] r, logic [DIM_W-1:0] k, logic [DIM_W-1:0] c);
        s_valid <= 1'b0;
        while (tracker.due_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SPARE;
        cfg_data  <= CFG_W'($urandom);
        @(posedge aclk);
        cfg_index <= CFG_ROWS_A;
        cfg_data  <= r;
        @(posedge aclk);
        cfg_index <= CFG_INNER_DIM;
        cfg_data  <= k;
        @(posedge aclk);
        cfg_index <= CFG_COLS_B;
        cfg_data  <= c;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.set_dims(r, k, c);
    endtask

    // Load every in-shape entry not yet written so that a compute never reads an unset one.
    task automatic fill_missing();
        for (int r = 0; r < tracker.n_rows; r++)
            for (int k = 0; k < tracker.n_inner; k++)
                if (!tracker.a_loaded[r*DIM + k])
                    send_item(CMD_LOAD_A, IDX_W'(r), IDX_W'(k), rand_value());
        for (int k = 0; k < tracker.n_inner; k++)
            for (int c = 0; c < tracker.n_cols; c++)
                if (!tracker.b_loaded[k*DIM + c])
                    send_item(CMD_LOAD_B, IDX_W'(k), IDX_W'(c), rand_value());
    endtask

    task automatic send_random_item();
        int                 pick;
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        pick = $urandom_range(0, 99);
        row  = IDX_W'($urandom);
        col  = IDX_W'($urandom);
        if (pick < 45) begin
            cmd = CMD_LOAD_A;
            row = draw_index(tracker.n_rows);
            col = draw_index(tracker.n_inner);
        end else if (pick < 80) begin
            cmd = CMD_LOAD_B;
            row = draw_index(tracker.n_inner);
            col = draw_index(tracker.n_cols);
        end else if (pick < 95) begin
            cmd = CMD_COMPUTE;
        end else begin
            cmd = CMD_UNUSED;
        end
        send_item(cmd, row, col, rand_value());
    endtask

    task automatic run_phase(logic [DIM_W-1:0] r, logic [DIM_W-1:0] k, logic [DIM_W-1:0] c,
                             int n_items);
        set_shape(r, k, c);
        no_gaps = ($urandom_range(0, 3) == 0);
        fill_missing();
        repeat (n_items) send_random_item();
        send_item(CMD_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), rand_value());
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_cmd     <= CMD_LOAD_A;
        s_row     <= '0;
        s_col     <= '0;
        s_value   <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extreme operands, ignored loads, unused command, degenerate shapes.
        set_shape(4'd2, 4'd2, 4'd2);
        send_item(CMD_LOAD_A, 3'd0, 3'd0, VAL_MOST_NEG);
        send_item(CMD_LOAD_A, 3'd0, 3'd1, VAL_MOST_NEG);
        send_item(CMD_LOAD_A, 3'd1, 3'd0, VAL_MOST_POS);
        send_item(CMD_LOAD_A, 3'd1, 3'd1, '0);
        send_item(CMD_LOAD_B, 3'd0, 3'd0, VAL_MOST_NEG);
        send_item(CMD_LOAD_B, 3'd1, 3'd0, VAL_MOST_NEG);
        send_item(CMD_LOAD_B, 3'd0, 3'd1, VAL_MOST_POS);
        send_item(CMD_LOAD_B, 3'd1, 3'd1, VAL_MINUS_ONE);
        send_item(CMD_LOAD_A, 3'd7, 3'd7, VAL_MOST_POS);
        send_item(CMD_LOAD_A, 3'd2, 3'd1, VAL_MOST_POS);
        send_item(CMD_LOAD_B, 3'd2, 3'd0, VAL_MOST_POS);
        send_item(CMD_LOAD_B, 3'd0, 3'd2, VAL_MOST_POS);
        send_item(CMD_UNUSED, 3'd7, 3'd7, VAL_MINUS_ONE);
        send_item(CMD_COMPUTE, 3'd0, 3'd0, '0);
        set_shape(4'd2, 4'd0, 4'd2);
        send_item(CMD_COMPUTE, 3'd7, 3'd7, VAL_MINUS_ONE);
        set_shape(4'd0, 4'd2, 4'd2);
        send_item(CMD_COMPUTE, 3'd0, 3'd0, '0);
        set_shape(4'd2, 4'd2, 4'd0);
        send_item(CMD_COMPUTE, 3'd0, 3'd0, '0);

        run_phase(4'd1, 4'd1, 4'd1, 2);
        run_phase(4'd3, 4'd5, 4'd2, 2);
        run_phase(4'd15, 4'd1, 4'd9, 2);
        run_phase(4'd4, 4'd8, 4'd1, 2);
        run_phase(4'd8, 4'd8, 4'd8, 2);
        // Hold the result side while the next compute waits behind a full product.
        hold_req = 1'b1;
        send_item(CMD_COMPUTE, 3'd0, 3'd0, '0);
        repeat (2) send_random_item();
        run_phase(4'd1, 4'd8, 4'd1, 2);
        run_phase(4'd8, 4'd2, 4'd8, 2);
        run_phase(4'd5, 4'd3, 4'd4, 2);
        run_phase(4'd15, 4'd15, 4'd15, 2);

        s_valid <= 1'b0;
        while (tracker.due_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.due_q.size() == 0)
            $display("matrix_multiply_engine_unit_tb passed");
        else
            $display("matrix_multiply_engine_unit_tb failed");
        $finish;
    end

    initial begin
        int stall;
        m_ready <= 1'b0;
        wait (aresetn);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 10);
            if (hold_req && !hold_done) begin
                stall     = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            tracker.check_element(m_out_row, m_out_col, m_product_value, m_last);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        wait (aresetn);
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
                quiet = 0;
            else
                quiet++;
        end
        $display("matrix_multiply_engine_unit_tb failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/mme_pkg.sv
hdl/mme_ctrl.sv
hdl/mme_dp.sv
hdl/matrix_multiply_engine_unit.sv
bench/matrix_multiply_engine_unit_tb.sv
